@@ hw/rtl/edf_pkg.sv @@
// edf_pkg: shared types, constants and codes for the EDF task selector.
// Used by edf_ctrl, edf_datapath and edf_task_selector; depends on nothing.
package edf_pkg;

    // Default sizing
    localparam int NUM_TASKS_DEF      = 8;
    localparam int TASK_TIME_BITS_DEF = 16;
    localparam int MAX_TASKS          = 8;
    localparam int SLOT_W             = 16;   // slot pitch inside a 64-bit register
    localparam int SLOTS_PER_REG      = 4;

    // Datapath widths
    localparam int TIME_W     = 32;
    localparam int DL_W       = 34;           // deadline / finish sums, no wrap
    localparam int NOW_MRG_W  = 33;           // now + margin
    localparam int IDLE_IN_W  = 32;
    localparam int IDLE_W     = 48;
    localparam int TASK_OUT_W = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MASK_W      = 8;
    localparam int MARGIN_W    = 16;

    localparam logic [MARGIN_W-1:0] SAFETY_MARGIN_RST = MARGIN_W'(1000);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REL_LO    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REL_HI    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXEC_LO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXEC_HI   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HF_MASK   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN    = 3'd5;

    // Input word
    typedef struct packed {
        logic [TIME_W-1:0]    now_time;
        logic [MASK_W-1:0]    alive_mask;
        logic [IDLE_IN_W-1:0] idle_time;
    } edf_in_t;

    // Result word
    typedef struct packed {
        logic [TASK_OUT_W-1:0] chosen_task;
        logic                  freq_high;
        logic [IDLE_W-1:0]     idle_total;
    } edf_out_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } edf_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;    // latch input word, clear scan state
        logic step;     // process the task under the scan counter
        logic finish;   // fold idle time, load result register
    } edf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;     // scan counter at the last task
        logic urgent;   // current task misses its deadline margin
        logic out_busy; // result register full and stalled
    } edf_stat_t;

endpackage

@@ hw/rtl/edf_ctrl.sv @@
// edf_ctrl: sequencing state machine for the EDF task selector.
// Depends on edf_pkg for state, command and status types.
module edf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output edf_pkg::edf_cmd_t    cmd,
    input  edf_pkg::edf_stat_t   stat
);

    edf_pkg::edf_state_t state_reg;
    edf_pkg::edf_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            edf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = edf_pkg::ST_SCAN;
                end
            end
            edf_pkg::ST_SCAN:
            begin
                if (stat.urgent || stat.last)
                begin
                    state_next = edf_pkg::ST_DONE;
                end
            end
            edf_pkg::ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = edf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = edf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            edf_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            edf_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            edf_pkg::ST_DONE:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/edf_datapath.sv @@
// edf_datapath: per-task deadline state, scan registers, idle sum and result register.
// Depends on edf_pkg; driven by commands from edf_ctrl.
module edf_datapath #(
    parameter int NUM_TASKS      = edf_pkg::NUM_TASKS_DEF,
    parameter int TASK_TIME_BITS = edf_pkg::TASK_TIME_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  edf_pkg::edf_in_t                           in_word,
    input  edf_pkg::edf_cmd_t                          cmd,
    output edf_pkg::edf_stat_t                         stat,
    input  logic [NUM_TASKS-1:0][TASK_TIME_BITS-1:0]   rel_slot,
    input  logic [NUM_TASKS-1:0][TASK_TIME_BITS-1:0]   exec_slot,
    input  logic [NUM_TASKS-1:0]                       hf_mask,
    input  logic [edf_pkg::MARGIN_W-1:0]               margin,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output edf_pkg::edf_out_t                          out_word
);

    localparam int IDX_W = $clog2(NUM_TASKS);

    // Item registers
    logic [edf_pkg::TIME_W-1:0]    now_reg;
    logic [edf_pkg::NOW_MRG_W-1:0] now_mrg_reg;
    logic [NUM_TASKS-1:0]          alive_reg;
    logic [edf_pkg::IDLE_IN_W-1:0] idle_in_reg;

    // Scan registers
    logic [IDX_W-1:0]              cnt_reg;
    logic                          found_reg;
    logic [edf_pkg::DL_W-1:0]      closest_reg;
    logic [IDX_W-1:0]              chosen_reg;
    logic                          freq_reg;

    // Per-task state
    logic [edf_pkg::DL_W-1:0]      dl_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0]          was_alive_reg;
    logic [edf_pkg::IDLE_W-1:0]    idle_sum_reg;

    // Result register
    logic                          out_valid_reg;
    edf_pkg::edf_out_t             out_word_reg;

    // Current task evaluation
    logic                          cur_alive;
    logic [edf_pkg::DL_W-1:0]      dl_eff;
    logic [edf_pkg::DL_W-1:0]      finish_time;
    logic                          urgent;
    logic                          better;
    logic [edf_pkg::IDLE_W:0]      idle_wide;
    logic [edf_pkg::IDLE_W-1:0]    idle_next;

    always_comb
    begin
        cur_alive   = alive_reg[cnt_reg];
        dl_eff      = was_alive_reg[cnt_reg] ? dl_reg[cnt_reg]
                    : edf_pkg::DL_W'(now_reg) + edf_pkg::DL_W'(rel_slot[cnt_reg]);
        finish_time = edf_pkg::DL_W'(now_mrg_reg) + edf_pkg::DL_W'(exec_slot[cnt_reg]);
        urgent      = cur_alive && (finish_time >= dl_eff);
        better      = cur_alive && (!found_reg || (dl_eff < closest_reg));
    end

    // Saturating idle accumulation
    always_comb
    begin
        idle_wide = {1'b0, idle_sum_reg} + (edf_pkg::IDLE_W + 1)'(idle_in_reg);
        idle_next = idle_wide[edf_pkg::IDLE_W] ? '1 : idle_wide[edf_pkg::IDLE_W-1:0];
    end

    always_comb
    begin
        stat.last     = (cnt_reg == IDX_W'(NUM_TASKS - 1));
        stat.urgent   = urgent;
        stat.out_busy = out_valid_reg && out_stall;
    end

    // Input latch (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            now_reg     <= in_word.now_time;
            now_mrg_reg <= edf_pkg::NOW_MRG_W'(in_word.now_time)
                         + edf_pkg::NOW_MRG_W'(margin);
            alive_reg   <= in_word.alive_mask[NUM_TASKS-1:0];
            idle_in_reg <= in_word.idle_time;
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            closest_reg <= '0;
            chosen_reg  <= '0;
            freq_reg    <= 1'b0;
        end
        else if (cmd.start)
        begin
            cnt_reg    <= '0;
            found_reg  <= 1'b0;
            chosen_reg <= '0;
            freq_reg   <= 1'b0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + IDX_W'(1);
            if (urgent)
            begin
                chosen_reg <= cnt_reg;
                freq_reg   <= 1'b1;
            end
            else if (better)
            begin
                found_reg   <= 1'b1;
                closest_reg <= dl_eff;
                chosen_reg  <= cnt_reg;
                freq_reg    <= hf_mask[cnt_reg];
            end
        end
    end

    // Per-task deadline and alive marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                dl_reg[i] <= '1;
            end
            was_alive_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (cur_alive)
            begin
                dl_reg[cnt_reg] <= dl_eff;
            end
            was_alive_reg[cnt_reg] <= cur_alive;
        end
    end

    // Idle sum and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            idle_sum_reg  <= idle_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_word_reg.chosen_task <= edf_pkg::TASK_OUT_W'(chosen_reg);
            out_word_reg.freq_high   <= freq_reg;
            out_word_reg.idle_total  <= idle_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A result is never loaded over a word that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled word");

    // Loading the result register raises valid next cycle
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result valid missing after finish");

    // An urgent task is chosen at high frequency
    a_urgent_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && urgent) |=> (freq_reg && (chosen_reg == $past(cnt_reg))))
        else $error("urgent task not selected at high frequency");

    // Commands are mutually exclusive
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

@@ hw/rtl/edf_task_selector.sv @@
// Energy-aware EDF task selector: one decision word per input word, scanning the
// task table one entry per cycle. An accepted word is latched, then the tasks are
// scanned up to NUM_TASKS (the scan stops early at the first urgent task), then
// the result register is loaded. The per-task scan through the shared compare
// unit sets how long a decision takes. A finished result waits in its own output
// register, so the next input word is taken while it is still stalled; the block
// only holds its result if the previous word has not yet been taken.
// Configuration registers are written through a plain indexed write port and
// must only change while idle.
// Depends on edf_pkg, edf_ctrl and edf_datapath.
module edf_task_selector #(
    parameter int NUM_TASKS      = edf_pkg::NUM_TASKS_DEF,
    parameter int TASK_TIME_BITS = edf_pkg::TASK_TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  edf_pkg::edf_in_t                    in_word,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output edf_pkg::edf_out_t                   out_word,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [edf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [edf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic [edf_pkg::CFG_DATA_W-1:0] rel_lo_reg;
    logic [edf_pkg::CFG_DATA_W-1:0] rel_hi_reg;
    logic [edf_pkg::CFG_DATA_W-1:0] exec_lo_reg;
    logic [edf_pkg::CFG_DATA_W-1:0] exec_hi_reg;
    logic [edf_pkg::MASK_W-1:0]     hf_mask_reg;
    logic [edf_pkg::MARGIN_W-1:0]   margin_reg;

    logic [NUM_TASKS-1:0][TASK_TIME_BITS-1:0] rel_slot;
    logic [NUM_TASKS-1:0][TASK_TIME_BITS-1:0] exec_slot;

    edf_pkg::edf_cmd_t  cmd;
    edf_pkg::edf_stat_t stat;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_lo_reg  <= '0;
            rel_hi_reg  <= '0;
            exec_lo_reg <= '0;
            exec_hi_reg <= '0;
            hf_mask_reg <= '0;
            margin_reg  <= edf_pkg::SAFETY_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                edf_pkg::REG_REL_LO:  rel_lo_reg  <= cfg_data;
                edf_pkg::REG_REL_HI:  rel_hi_reg  <= cfg_data;
                edf_pkg::REG_EXEC_LO: exec_lo_reg <= cfg_data;
                edf_pkg::REG_EXEC_HI: exec_hi_reg <= cfg_data;
                edf_pkg::REG_HF_MASK: hf_mask_reg <= cfg_data[edf_pkg::MASK_W-1:0];
                edf_pkg::REG_MARGIN:  margin_reg  <= cfg_data[edf_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-task slots, low TASK_TIME_BITS of each 16-bit field
    for (genvar t = 0; t < NUM_TASKS; t++)
    begin : g_slot
        localparam int LSB = (t % edf_pkg::SLOTS_PER_REG) * edf_pkg::SLOT_W;
        if (t < edf_pkg::SLOTS_PER_REG)
        begin : g_lo
            assign rel_slot[t]  = rel_lo_reg[LSB +: TASK_TIME_BITS];
            assign exec_slot[t] = exec_lo_reg[LSB +: TASK_TIME_BITS];
        end
        else
        begin : g_hi
            assign rel_slot[t]  = rel_hi_reg[LSB +: TASK_TIME_BITS];
            assign exec_slot[t] = exec_hi_reg[LSB +: TASK_TIME_BITS];
        end
    end

    edf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    edf_datapath #(
        .NUM_TASKS      (NUM_TASKS),
        .TASK_TIME_BITS (TASK_TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .rel_slot  (rel_slot),
        .exec_slot (exec_slot),
        .hf_mask   (hf_mask_reg[NUM_TASKS-1:0]),
        .margin    (margin_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
